// ===== design/rau_pkg.sv =====
package rau_pkg;

  // Width the reduced result must fit; the operand fields stay 32/31 bits.
  localparam int VALUE_WIDTH = 32;

  localparam int NUM_W  = 32;  // numerator field
  localparam int DEN_W  = 31;  // denominator field
  localparam int WIDE_W = 64;  // cross products and gcd words
  localparam int ALU_W  = 65;  // shared add/sub, one guard bit for sign
  localparam int MUL_W  = 33;  // signed multiplier operand

  localparam logic [WIDE_W-1:0] FIT_LIM = WIDE_W'(1) << (VALUE_WIDTH - 1);
  localparam logic [WIDE_W-1:0] FIT_MAX = FIT_LIM - WIDE_W'(1);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_LT  = 3'd5,
    OP_LE  = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

// ===== design/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit. Each transaction carries an opcode and two signed
// rationals a = a_num/a_den and b = b_num/b_den (positive 31-bit denominators)
// and returns one result transaction: add, subtract, multiply, divide and
// negate give a gcd-reduced fraction with the sign on the numerator (zero is
// 0/1), the two compares give compare_true with a zero fraction. status flags
// division by zero (unreduced denominator of zero) and overflow (reduced
// fraction wider than VALUE_WIDTH); both return 0/0. Opcode 7 returns all
// zeros. The block works on one transaction at a time and holds in_stall high
// from acceptance until its result has been taken. All arithmetic runs on one
// registered 33x33 multiplier and one 65-bit add/sub unit under a sequencer.
// Compares and opcode 7 pass through the multiplier and the combine step only.
// The other opcodes go on through sign handling, binary gcd (one shift or one
// subtract per cycle) and two 64-bit restoring divisions by the gcd, then a
// range check and sign. The sequencer returns to idle once the result is taken.
module rational_arithmetic_unit_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // operand channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_opcode,
  input  logic signed [rau_pkg::NUM_W-1:0]  in_a_num,
  input  logic [rau_pkg::DEN_W-1:0]         in_a_den,
  input  logic signed [rau_pkg::NUM_W-1:0]  in_b_num,
  input  logic [rau_pkg::DEN_W-1:0]         in_b_den,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rau_pkg::NUM_W-1:0]  out_res_num,
  output logic [rau_pkg::DEN_W-1:0]         out_res_den,
  output logic                              out_compare_true,
  output logic [1:0]                        out_status
);

  localparam int W = rau_pkg::WIDE_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,  // waiting for a transaction
    S_MUL  = 10'b00_0000_0010,  // three products through the multiplier
    S_COMB = 10'b00_0000_0100,  // combine products, compare, zero check
    S_ABSX = 10'b00_0000_1000,  // magnitude of numerator
    S_ABSY = 10'b00_0001_0000,  // magnitude of denominator
    S_GCD  = 10'b00_0010_0000,  // binary gcd, one step per cycle
    S_DIVN = 10'b00_0100_0000,  // numerator / gcd
    S_DIVD = 10'b00_1000_0000,  // denominator / gcd
    S_FIT  = 10'b01_0000_0000,  // range check and sign
    S_DONE = 10'b10_0000_0000   // result held until taken
  } state_t;

  state_t state_r, state_nxt;

  // captured operands
  logic [2:0]                       op_r, op_nxt;
  logic signed [rau_pkg::NUM_W-1:0] an_r, an_nxt, bn_r, bn_nxt;
  logic [rau_pkg::DEN_W-1:0]        ad_r, ad_nxt, bd_r, bd_nxt;

  // products: m0 doubles as the unreduced numerator, m2 is the denominator
  logic [W-1:0] m0_r, m0_nxt, m1_r, m1_nxt, m2_r, m2_nxt;
  logic [W-1:0] mn_r, mn_nxt, md_r, md_nxt;   // magnitudes
  logic [W-1:0] g_r, g_nxt;                   // gcd
  logic [W-1:0] qn_r, qn_nxt;                 // reduced numerator magnitude
  // gcd working pair; reused as remainder (u) and quotient (v) when dividing
  logic [W-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [5:0]   k_r, k_nxt;                   // common power of two
  logic [5:0]   cnt_r, cnt_nxt;
  logic         xneg_r, xneg_nxt, neg_r, neg_nxt;

  // result register
  logic signed [rau_pkg::NUM_W-1:0] res_num_r, res_num_nxt;
  logic [rau_pkg::DEN_W-1:0]        res_den_r, res_den_nxt;
  logic                             cmp_r, cmp_nxt;
  logic [1:0]                       status_r, status_nxt;

  rau_pkg::mul_req_t              mul_req;
  logic signed [2*rau_pkg::MUL_W-1:0] prod;
  rau_pkg::alu_req_t              alu_req;
  logic [rau_pkg::ALU_W-1:0]      alu_res;

  logic signed [rau_pkg::MUL_W-1:0] an_x, ad_x, bn_x, bd_x;
  logic [W-1:0] rem_step, quo_step;
  logic         fit_ovf;

  rau_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  rau_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign an_x = {an_r[rau_pkg::NUM_W-1], an_r};
  assign bn_x = {bn_r[rau_pkg::NUM_W-1], bn_r};
  assign ad_x = {2'b00, ad_r};
  assign bd_x = {2'b00, bd_r};

  // restoring division step: shift next dividend bit into the remainder
  assign rem_step = alu_res[rau_pkg::ALU_W-1] ? {u_r[W-2:0], v_r[W-1]} : alu_res[W-1:0];
  assign quo_step = {v_r[W-2:0], ~alu_res[rau_pkg::ALU_W-1]};

  assign fit_ovf = (v_r > rau_pkg::FIT_MAX) ||
                   (neg_r ? (qn_r > rau_pkg::FIT_LIM) : (qn_r > rau_pkg::FIT_MAX));

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    an_nxt      = an_r;
    ad_nxt      = ad_r;
    bn_nxt      = bn_r;
    bd_nxt      = bd_r;
    m0_nxt      = m0_r;
    m1_nxt      = m1_r;
    m2_nxt      = m2_r;
    mn_nxt      = mn_r;
    md_nxt      = md_r;
    g_nxt       = g_r;
    qn_nxt      = qn_r;
    u_nxt       = u_r;
    v_nxt       = v_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    xneg_nxt    = xneg_r;
    neg_nxt     = neg_r;
    res_num_nxt = res_num_r;
    res_den_nxt = res_den_r;
    cmp_nxt     = cmp_r;
    status_nxt  = status_r;

    mul_req.a   = an_x;
    mul_req.b   = bd_x;
    alu_req.sub = 1'b1;
    alu_req.a   = '0;
    alu_req.b   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_opcode;
          an_nxt      = in_a_num;
          ad_nxt      = in_a_den;
          bn_nxt      = in_b_num;
          bd_nxt      = in_b_den;
          res_num_nxt = '0;
          res_den_nxt = '0;
          cmp_nxt     = 1'b0;
          status_nxt  = rau_pkg::ST_OK;
          cnt_nxt     = '0;
          state_nxt   = S_MUL;
        end
      end

      S_MUL: begin
        // issue at counts 0..2; each registered product is taken in the following cycle
        case (cnt_r[1:0])
          2'd0: begin
            mul_req.a = an_x;
            if (op_r == rau_pkg::OP_MUL) begin
              mul_req.b = bn_x;
            end else if (op_r == rau_pkg::OP_NEG) begin
              mul_req.b = '1;   // times minus one
            end else begin
              mul_req.b = bd_x;
            end
          end
          2'd1: begin
            mul_req.a = ad_x;
            mul_req.b = bn_x;
            m0_nxt    = prod[W-1:0];
          end
          2'd2: begin
            mul_req.a = ad_x;
            if (op_r == rau_pkg::OP_DIV) begin
              mul_req.b = bn_x;
            end else if (op_r == rau_pkg::OP_NEG) begin
              mul_req.b = rau_pkg::MUL_W'(1);
            end else begin
              mul_req.b = bd_x;
            end
            m1_nxt = prod[W-1:0];
          end
          default: begin
            m2_nxt    = prod[W-1:0];
            state_nxt = S_COMB;
          end
        endcase
        cnt_nxt = cnt_r + 6'd1;
      end

      S_COMB: begin
        alu_req.a   = {m0_r[W-1], m0_r};
        alu_req.b   = {m1_r[W-1], m1_r};
        alu_req.sub = (op_r != rau_pkg::OP_ADD);
        case (op_r)
          rau_pkg::OP_LT: begin
            cmp_nxt   = alu_res[rau_pkg::ALU_W-1];
            state_nxt = S_DONE;
          end
          rau_pkg::OP_LE: begin
            cmp_nxt   = alu_res[rau_pkg::ALU_W-1] || (alu_res == '0);
            state_nxt = S_DONE;
          end
          rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL,
          rau_pkg::OP_DIV, rau_pkg::OP_NEG: begin
            if (m2_r == '0) begin
              status_nxt = rau_pkg::ST_DIV_ZERO;
              state_nxt  = S_DONE;
            end else begin
              if (op_r == rau_pkg::OP_ADD || op_r == rau_pkg::OP_SUB) begin
                m0_nxt = alu_res[W-1:0];
              end
              state_nxt = S_ABSX;
            end
          end
          default: begin
            state_nxt = S_DONE;   // unused opcode: all zero
          end
        endcase
      end

      S_ABSX: begin
        alu_req.b = {m0_r[W-1], m0_r};
        mn_nxt    = m0_r[W-1] ? alu_res[W-1:0] : m0_r;
        u_nxt     = mn_nxt;
        xneg_nxt  = m0_r[W-1];
        state_nxt = S_ABSY;
      end

      S_ABSY: begin
        alu_req.b = {m2_r[W-1], m2_r};
        md_nxt    = m2_r[W-1] ? alu_res[W-1:0] : m2_r;
        v_nxt     = md_nxt;
        neg_nxt   = (mn_r != '0) && (xneg_r ^ m2_r[W-1]);
        k_nxt     = '0;
        state_nxt = S_GCD;
      end

      S_GCD: begin
        alu_req.a = {1'b0, u_r};
        alu_req.b = {1'b0, v_r};
        if (u_r == '0) begin
          g_nxt     = v_r << k_r;
          u_nxt     = '0;
          v_nxt     = mn_r;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 6'd1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (alu_res[rau_pkg::ALU_W-1]) begin
          u_nxt = v_r;   // keep u the larger
          v_nxt = u_r;
        end else begin
          u_nxt = alu_res[W:1];   // both odd: difference is even
        end
      end

      S_DIVN, S_DIVD: begin
        alu_req.a = {1'b0, u_r[W-2:0], v_r[W-1]};
        alu_req.b = {1'b0, g_r};
        u_nxt     = rem_step;
        v_nxt     = quo_step;
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'(W - 1)) begin
          if (state_r == S_DIVN) begin
            qn_nxt    = quo_step;
            u_nxt     = '0;
            v_nxt     = md_r;
            cnt_nxt   = '0;
            state_nxt = S_DIVD;
          end else begin
            state_nxt = S_FIT;
          end
        end
      end

      S_FIT: begin
        alu_req.b = {1'b0, qn_r};
        if (fit_ovf) begin
          status_nxt = rau_pkg::ST_OVERFLOW;
        end else begin
          res_num_nxt = neg_r ? alu_res[rau_pkg::NUM_W-1:0] : qn_r[rau_pkg::NUM_W-1:0];
          res_den_nxt = v_r[rau_pkg::DEN_W-1:0];
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
    bn_r      <= bn_nxt;
    bd_r      <= bd_nxt;
    m0_r      <= m0_nxt;
    m1_r      <= m1_nxt;
    m2_r      <= m2_nxt;
    mn_r      <= mn_nxt;
    md_r      <= md_nxt;
    g_r       <= g_nxt;
    qn_r      <= qn_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    xneg_r    <= xneg_nxt;
    neg_r     <= neg_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    cmp_r     <= cmp_nxt;
    status_r  <= status_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_DONE);
  assign out_res_num      = res_num_r;
  assign out_res_den      = res_den_r;
  assign out_compare_true = cmp_r;
  assign out_status       = status_r;

  // no new transaction while a result is pending
  a_busy_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // an accepted transaction never produces a result in the next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("result too early after acceptance");

  // error results carry a zero fraction and no compare outcome
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != rau_pkg::ST_OK) |->
      (out_res_num == '0 && out_res_den == '0 && !out_compare_true))
    else $error("error result not cleared");

endmodule

// ===== design/rau_mul.sv =====
module rau_mul (
  input  logic                                   clk,
  input  rau_pkg::mul_req_t                      req,
  output logic signed [2*rau_pkg::MUL_W-1:0]     prod
);

  logic signed [2*rau_pkg::MUL_W-1:0] prod_r;

  // one signed product per cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= $signed(req.a) * $signed(req.b);
  end

  assign prod = prod_r;

endmodule

// ===== design/rau_alu.sv =====
module rau_alu (
  input  rau_pkg::alu_req_t             req,
  output logic [rau_pkg::ALU_W-1:0]     res
);

  logic [rau_pkg::ALU_W-1:0] b_eff;

  // a + b or a - b; bit 64 is the sign of the result
  assign b_eff = req.sub ? ~req.b : req.b;
  assign res   = req.a + b_eff + rau_pkg::ALU_W'(req.sub);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam logic signed [rau_pkg::NUM_W-1:0] NUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [rau_pkg::NUM_W-1:0] NUM_MIN = 32'sh8000_0000;
  localparam logic [rau_pkg::DEN_W-1:0]        DEN_MAX = 31'h7fff_ffff;
  // opcode 7 is not in opcode_t; the DUT must return all zeros for it
  localparam logic [2:0]                       OP_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_AFTER   = 300;   // operand transactions before long hold
  localparam int HOLD_CYCLES  = 700;
  // must cover the worst item's gcd and divides, plus the long hold
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 500;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

  // Expected result FIFO plus the arithmetic predictor. The DUT handles one
  // transaction at a time, so results come back in order.
  class rational_scoreboard;
    typedef struct {
      logic [2:0]                       op;
      logic signed [rau_pkg::NUM_W-1:0] num;
      logic [rau_pkg::DEN_W-1:0]        den;
      logic                             cmp;
      rau_pkg::status_t                 st;
    } rational_result_t;

    rational_result_t pending_results[$];
    int errors;
    int printed;
    int op_count[8];
    int n_ok, n_div_zero, n_overflow, n_cmp_true, n_checked;

    function int outstanding();
      return pending_results.size();
    endfunction

    task report(string what);
      errors++;
      // keep the log short if the DUT is badly broken
      if (printed < 100) begin
        printed++;
        $display("[%0t] ERROR %s", $realtime, what);
      end
    endtask

    // Exact 64-bit arithmetic, gcd reduction, sign on the numerator.
    function rational_result_t compute_rational(logic [2:0] op,
                                                logic signed [rau_pkg::NUM_W-1:0] an,
                                                logic [rau_pkg::DEN_W-1:0] ad,
                                                logic signed [rau_pkg::NUM_W-1:0] bn,
                                                logic [rau_pkg::DEN_W-1:0] bd);
      longint sa_n, sa_d, sb_n, sb_d, x, y;
      longint unsigned mag_n, mag_d, p, q, t, fit_lim, wide_num;
      bit neg;
      rational_result_t r;
      r.op  = op;
      r.num = '0;
      r.den = '0;
      r.cmp = 1'b0;
      r.st  = rau_pkg::ST_OK;
      sa_n = an;
      sa_d = ad;
      sb_n = bn;
      sb_d = bd;
      x = 0;
      y = 0;
      case (op)
        rau_pkg::OP_ADD: begin
          x = sa_n * sb_d + sa_d * sb_n;
          y = sa_d * sb_d;
        end
        rau_pkg::OP_SUB: begin
          x = sa_n * sb_d - sa_d * sb_n;
          y = sa_d * sb_d;
        end
        rau_pkg::OP_MUL: begin
          x = sa_n * sb_n;
          y = sa_d * sb_d;
        end
        rau_pkg::OP_DIV: begin
          x = sa_n * sb_d;
          y = sa_d * sb_n;
        end
        rau_pkg::OP_NEG: begin
          x = -sa_n;
          y = sa_d;
        end
        // compares use the raw cross products, zero denominators included
        rau_pkg::OP_LT: begin
          r.cmp = (sa_n * sb_d < sa_d * sb_n);
          return r;
        end
        rau_pkg::OP_LE: begin
          r.cmp = (sa_n * sb_d <= sa_d * sb_n);
          return r;
        end
        default: return r;
      endcase
      if (y == 0) begin
        r.st = rau_pkg::ST_DIV_ZERO;
        return r;
      end
      mag_n = (x < 0) ? -x : x;
      mag_d = (y < 0) ? -y : y;
      neg = (mag_n != 0) && ((x < 0) != (y < 0));
      p = mag_n;
      q = mag_d;
      while (q != 0) begin
        t = p % q;
        p = q;
        q = t;
      end
      mag_n = mag_n / p;
      mag_d = mag_d / p;
      fit_lim = 64'd1 << (rau_pkg::VALUE_WIDTH - 1);
      if (mag_d > fit_lim - 1 || (neg ? mag_n > fit_lim : mag_n > fit_lim - 1)) begin
        r.st = rau_pkg::ST_OVERFLOW;
      end else begin
        wide_num = neg ? -mag_n : mag_n;
        r.num = wide_num[rau_pkg::NUM_W-1:0];
        r.den = mag_d[rau_pkg::DEN_W-1:0];
      end
      return r;
    endfunction

    function void note_operands(logic [2:0] op, logic signed [rau_pkg::NUM_W-1:0] an,
                                logic [rau_pkg::DEN_W-1:0] ad,
                                logic signed [rau_pkg::NUM_W-1:0] bn,
                                logic [rau_pkg::DEN_W-1:0] bd);
      op_count[op]++;
      pending_results.push_back(compute_rational(op, an, ad, bn, bd));
    endfunction

    task check_result(logic signed [rau_pkg::NUM_W-1:0] num,
                      logic [rau_pkg::DEN_W-1:0] den,
                      logic cmp, rau_pkg::status_t st);
      rational_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d/%0d status %0d with no transaction outstanding",
                         num, den, st));
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (num !== e.num)
          report($sformatf("op %0d res_num: expected %0d, got %0d", e.op, e.num, num));
        if (den !== e.den)
          report($sformatf("op %0d res_den: expected %0d, got %0d", e.op, e.den, den));
        if (cmp !== e.cmp)
          report($sformatf("op %0d compare_true: expected %0d, got %0d",
                           e.op, e.cmp, cmp));
        if (st !== e.st)
          report($sformatf("op %0d status: expected %0d, got %0d", e.op, e.st, st));
        case (e.st)
          rau_pkg::ST_DIV_ZERO: n_div_zero++;
          rau_pkg::ST_OVERFLOW: n_overflow++;
          default:              n_ok++;
        endcase
        if (e.cmp) n_cmp_true++;
      end
    endtask

    task close_out();
      rational_result_t e;
      while (pending_results.size() != 0) begin
        e = pending_results.pop_front();
        report($sformatf("op %0d result never returned", e.op));
      end
      $display("Covered %0d: add %0d sub %0d mul %0d div %0d neg %0d lt %0d le %0d unused %0d",
               n_checked, op_count[0], op_count[1], op_count[2], op_count[3],
               op_count[4], op_count[5], op_count[6], op_count[7]);
      $display("Outcomes: ok %0d, divide by zero %0d, overflow %0d, compares true %0d",
               n_ok, n_div_zero, n_overflow, n_cmp_true);
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [2:0]                       in_opcode = '0;
  logic signed [rau_pkg::NUM_W-1:0] in_a_num = '0;
  logic [rau_pkg::DEN_W-1:0]        in_a_den = '0;
  logic signed [rau_pkg::NUM_W-1:0] in_b_num = '0;
  logic [rau_pkg::DEN_W-1:0]        in_b_den = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [rau_pkg::NUM_W-1:0] out_res_num;
  logic [rau_pkg::DEN_W-1:0]        out_res_den;
  logic                             out_compare_true;
  logic [1:0]                       out_status;

  rational_scoreboard sb = new();
  int n_accepted = 0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  rational_arithmetic_unit_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_a_num         (in_a_num),
    .in_a_den         (in_a_den),
    .in_b_num         (in_b_num),
    .in_b_den         (in_b_den),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_res_num      (out_res_num),
    .out_res_den      (out_res_den),
    .out_compare_true (out_compare_true),
    .out_status       (out_status)
  );

  // Monitors sample at the rising edge, before any NBA of that edge lands.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_operands(in_opcode, in_a_num, in_a_den, in_b_num, in_b_den);
      n_accepted <= n_accepted + 1;
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_res_num, out_res_den, out_compare_true,
                      rau_pkg::status_t'(out_status));
  end

  // Watchdog: counts edges at which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side back-pressure: random spans of free flow, light and heavy
  // random stalls and a fixed beat, plus one long hold so that the DUT
  // stays full and stalls its operand side while the sender keeps offering.
  initial begin : rx_pattern
    rx_mode_t mode;
    int span;
    int beat;
    bit hold_done;
    hold_done = 1'b0;
    beat = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        beat++;
        if (!hold_done && n_accepted >= HOLD_AFTER) begin
          hold_done = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:  out_stall <= ((beat % 5) < 3);
        endcase
      end
    end
  end

  // Offers one operand transaction and returns at the edge that takes it.
  // in_valid stays high so the next call can follow without a bubble.
  task automatic send_operands(input logic [2:0] op,
                               input logic signed [rau_pkg::NUM_W-1:0] an,
                               input logic [rau_pkg::DEN_W-1:0] ad,
                               input logic signed [rau_pkg::NUM_W-1:0] bn,
                               input logic [rau_pkg::DEN_W-1:0] bd);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_a_num  <= an;
    in_a_den  <= ad;
    in_b_num  <= bn;
    in_b_den  <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Numerators: extremes, full-range noise, and small values with common
  // factors so that gcd reduction does real work.
  function automatic logic signed [rau_pkg::NUM_W-1:0] pick_num();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return NUM_MIN;
          1: return NUM_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return (int'($urandom_range(0, 200)) - 100) * int'($urandom_range(1, 12));
    endcase
  endfunction

  // Denominators: zero now and then, extremes, full range and small values.
  function automatic logic [rau_pkg::DEN_W-1:0] pick_den();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return DEN_MAX;
      2: return 31'd1;
      3, 4, 5, 6: return 31'($urandom);
      default: return 31'($urandom_range(1, 60) * $urandom_range(1, 12));
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    int burst;
    int gap;
    logic [2:0] op;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reductions, sign handling, every opcode, errors and limits.
    send_operands(rau_pkg::OP_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);      // 5/6
    send_operands(rau_pkg::OP_SUB, 32'sd1, 31'd2, 32'sd2, 31'd4);      // zero gives 0/1
    send_operands(rau_pkg::OP_MUL, 32'sd2, 31'd3, 32'sd3, 31'd4);      // 1/2
    send_operands(rau_pkg::OP_DIV, 32'sd3, 31'd4, -32'sd3, 31'd8);     // sign moves up
    send_operands(rau_pkg::OP_DIV, 32'sd5, 31'd1, -32'sd10, 31'd3);    // -3/2
    send_operands(rau_pkg::OP_DIV, 32'sd1, 31'd2, 32'sd0, 31'd5);      // divide by zero
    send_operands(rau_pkg::OP_DIV, 32'sd0, 31'd1, 32'sd0, 31'd1);      // 0/0 divide
    send_operands(rau_pkg::OP_DIV, 32'sd1, 31'd1, 32'sd1, 31'd0);      // zero b_den: 0/1
    send_operands(rau_pkg::OP_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1);      // zero a_den
    send_operands(rau_pkg::OP_NEG, NUM_MIN, 31'd1, 32'sd0, 31'd1);     // +2^31 overflows
    send_operands(rau_pkg::OP_NEG, 32'sd0, 31'd7, NUM_MAX, DEN_MAX);   // 0/1
    send_operands(rau_pkg::OP_NEG, NUM_MAX, DEN_MAX, NUM_MIN, 31'd0);  // -1/1
    send_operands(rau_pkg::OP_MUL, NUM_MIN, 31'd1, NUM_MIN, 31'd1);    // 2^62 overflow
    send_operands(rau_pkg::OP_MUL, NUM_MIN, 31'd1, 32'sd1, 31'd1);     // most negative fits
    send_operands(rau_pkg::OP_MUL, 32'sd0, DEN_MAX, NUM_MIN, DEN_MAX); // 0/1
    // denominator too wide
    send_operands(rau_pkg::OP_ADD, 32'sd1, DEN_MAX, 32'sd1, DEN_MAX - 31'd1);
    send_operands(rau_pkg::OP_ADD, NUM_MAX, 31'd1, NUM_MAX, 31'd1);    // positive overflow
    send_operands(rau_pkg::OP_SUB, NUM_MIN, 31'd1, NUM_MAX, 31'd1);    // negative overflow
    send_operands(rau_pkg::OP_DIV, NUM_MAX, 31'd1, NUM_MIN, 31'd1);    // den 2^31 too wide
    send_operands(rau_pkg::OP_LT, 32'sd1, 31'd2, 32'sd2, 31'd4);       // equal: false
    send_operands(rau_pkg::OP_LE, 32'sd1, 31'd2, 32'sd2, 31'd4);       // equal: true
    send_operands(rau_pkg::OP_LT, -32'sd1, 31'd3, 32'sd1, 31'd3);      // true
    send_operands(rau_pkg::OP_LE, 32'sd5, 31'd0, 32'sd3, 31'd0);       // zero dens: 0 <= 0
    send_operands(rau_pkg::OP_LT, NUM_MIN, DEN_MAX, NUM_MAX, 31'd1);
    send_operands(OP_UNUSED, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX);      // all-zero result

    // Random bursts with random gaps; some gaps are zero for back-to-back.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
        send_operands(op, pick_num(), pick_den(), pick_num(), pick_den());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain, then linger long enough to catch a stray extra result.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
